[hw/rtl/srpg_pkg.sv]
// Shared types, codes and helpers for the stepper ramp pulse generator.
// No dependencies; imported by the core, the divider and the testbench.
`default_nettype none

package srpg_pkg;

    // Command codes on the func field
    localparam logic [2:0] FUNC_TICK      = 3'd0;
    localparam logic [2:0] FUNC_DEFAULT   = 3'd1;
    localparam logic [2:0] FUNC_COUNTED   = 3'd2;
    localparam logic [2:0] FUNC_RAMP_UP   = 3'd3;
    localparam logic [2:0] FUNC_RAMP_DOWN = 3'd4;

    // Configuration register indexes
    localparam logic [1:0] REG_DEFAULT_COUNT = 2'd0;
    localparam logic [1:0] REG_START_DELAY   = 2'd1;
    localparam logic [1:0] REG_MIN_DELAY     = 2'd2;

    // Reset values of the configuration registers
    localparam logic [15:0] RST_DEFAULT_COUNT = 16'd200;
    localparam logic [15:0] RST_START_DELAY   = 16'd1000;
    localparam logic [15:0] RST_MIN_DELAY     = 16'd100;

    // Widths of the ramp divider: 2a is 25 bits, 4i+1 is 18 bits
    localparam int unsigned DIVIDEND_W = 25;
    localparam int unsigned DIVISOR_W  = 18;

    typedef enum logic [1:0] {
        MODE_IDLE,
        MODE_CONST,
        MODE_UP,
        MODE_DOWN
    } mode_t;

    // Integer half period of a 16.8 value; zero runs as one tick
    function automatic logic [15:0] eff_delay(input logic [23:0] accum);
        logic [15:0] d;
        d = accum[23:8];
        return (d == 16'd0) ? 16'd1 : d;
    endfunction

endpackage

`default_nettype wire

[hw/rtl/stepper_ramp_pulse_generator_core.sv]
// Stepper step-pulse generator with a linear acceleration ramp and a delay table.
// Each item is latched, executed, and then written to the output register; a ramp-down
// command or step reads the table, and a ramp-up step boundary runs the serial divider.
// One item at a time: the next item is taken once the result is in the output register,
// which waits while the output is stalled.
// Reset (aresetn, synchronous, active low) clears control state; the table is not cleared.
`default_nettype none

module stepper_ramp_pulse_generator_core #(
    parameter int unsigned TABLE_DEPTH = 1024
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // command / tick input
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [2:0]  s_func,
    input  wire logic [15:0] s_pulse_delay,
    input  wire logic [15:0] s_step_count,
    // result output
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic             m_step_pulse,
    output logic             m_busy_res,
    output logic             m_rejected,
    output logic             m_step_done,
    output logic [15:0]      m_current_delay,
    // configuration writes
    input  wire logic        cfg_wr_en,
    input  wire logic [1:0]  cfg_addr,
    input  wire logic [15:0] cfg_wr_data
);
    import srpg_pkg::*;

    localparam int unsigned AW  = $clog2(TABLE_DEPTH);
    localparam int unsigned LW  = $clog2(TABLE_DEPTH + 1);
    localparam logic [16:0] DEPTH_W = 17'(TABLE_DEPTH);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_RD,
        ST_DIV,
        ST_OUT
    } state_t;

    state_t         state_reg;
    mode_t          mode_reg;

    // configuration
    logic [15:0]    dflt_cnt_reg;
    logic [15:0]    start_dly_reg;
    logic [15:0]    min_dly_reg;

    // latched item
    logic [2:0]     func_reg;
    logic [15:0]    pd_reg;
    logic [15:0]    cnt_reg;

    // move state
    logic [15:0]    hc_reg;
    logic           pulse_reg;
    logic [15:0]    steps_reg;
    logic [15:0]    idx_reg;
    logic [23:0]    accum_reg;
    logic [LW-1:0]  len_reg;
    logic           rej_reg;
    logic           done_reg;

    // output register
    logic           m_valid_reg;
    logic           m_pulse_reg;
    logic           m_busy_reg;
    logic           m_rej_reg;
    logic           m_done_reg;
    logic [15:0]    m_delay_reg;

    // RAM and divider hookup
    logic           ram_we;
    logic [AW-1:0]  ram_addr;
    logic [15:0]    ram_wdata;
    logic [15:0]    ram_rdata;
    logic           div_start;
    logic           div_done;
    logic [DIVIDEND_W-1:0] div_quot;

    // datapath helpers
    logic           is_cmd;
    logic           busy;
    logic           boundary;
    logic [15:0]    hc_dec;
    logic [15:0]    sl_dec;
    logic [15:0]    idx_inc;
    logic [15:0]    idx_dec;
    logic [16:0]    len_ext;
    logic [16:0]    n_down;
    logic [16:0]    n_m1;
    logic           idx_in_range;
    logic [25:0]    diff;
    logic [23:0]    floor_v;
    logic [23:0]    accum_new;
    logic [15:0]    rd_dly;

    srpg_ram #(
        .WIDTH (16),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .aclk  (aclk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    srpg_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend ({accum_reg, 1'b0}),
        .divisor  ({idx_inc, 2'b01}),
        .done     (div_done),
        .quotient (div_quot)
    );

    // Decode and next-delay arithmetic
    always_comb begin
        is_cmd   = (func_reg == FUNC_DEFAULT) || (func_reg == FUNC_COUNTED) ||
                   (func_reg == FUNC_RAMP_UP) || (func_reg == FUNC_RAMP_DOWN);
        busy     = mode_reg != MODE_IDLE;
        hc_dec   = hc_reg - 16'd1;
        sl_dec   = steps_reg - 16'd1;
        idx_inc  = idx_reg + 16'd1;
        idx_dec  = idx_reg - 16'd1;
        len_ext  = 17'(len_reg);
        n_down   = ({1'b0, cnt_reg} < len_ext) ? {1'b0, cnt_reg} : len_ext;
        n_m1     = n_down - 17'd1;
        // tick that ends the low half of a step with more steps to go
        boundary = !is_cmd && busy && (hc_dec == 16'd0) && !pulse_reg && (sl_dec != 16'd0);
        idx_in_range = {1'b0, idx_reg} < DEPTH_W;
        // a - 2a/(4i+1), clamped to the floor; wrap shows up as a huge value
        diff      = {2'b00, accum_reg} - {1'b0, div_quot};
        floor_v   = {min_dly_reg, 8'h00};
        accum_new = (diff < {2'b00, floor_v}) ? floor_v : diff[23:0];
        rd_dly    = (ram_rdata == 16'd0) ? 16'd1 : ram_rdata;
    end

    // Table port and divider start
    always_comb begin
        ram_we    = 1'b0;
        ram_addr  = idx_reg[AW-1:0];
        ram_wdata = accum_new[23:8];
        div_start = 1'b0;
        unique case (state_reg)
            ST_EXEC: begin
                if (is_cmd && !busy) begin
                    if (func_reg == FUNC_RAMP_UP && cnt_reg != 16'd0) begin
                        ram_we    = 1'b1;
                        ram_addr  = '0;
                        ram_wdata = start_dly_reg;
                    end else if (func_reg == FUNC_RAMP_DOWN) begin
                        ram_addr = n_m1[AW-1:0];
                    end
                end else if (boundary) begin
                    if (mode_reg == MODE_UP) begin
                        div_start = 1'b1;
                    end else if (mode_reg == MODE_DOWN) begin
                        ram_addr = idx_dec[AW-1:0];
                    end
                end
            end
            ST_DIV: begin
                ram_we = div_done && idx_in_range;
            end
            default: begin
            end
        endcase
    end

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dflt_cnt_reg  <= RST_DEFAULT_COUNT;
            start_dly_reg <= RST_START_DELAY;
            min_dly_reg   <= RST_MIN_DELAY;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                REG_DEFAULT_COUNT: dflt_cnt_reg  <= cfg_wr_data;
                REG_START_DELAY:   start_dly_reg <= cfg_wr_data;
                REG_MIN_DELAY:     min_dly_reg   <= cfg_wr_data;
                default: begin
                end
            endcase
        end
    end

    // Sequencer: state, move registers and the output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            mode_reg    <= MODE_IDLE;
            hc_reg      <= '0;
            pulse_reg   <= 1'b0;
            steps_reg   <= '0;
            idx_reg     <= '0;
            accum_reg   <= '0;
            len_reg     <= '0;
            rej_reg     <= 1'b0;
            done_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        func_reg  <= s_func;
                        pd_reg    <= s_pulse_delay;
                        cnt_reg   <= s_step_count;
                        rej_reg   <= 1'b0;
                        done_reg  <= 1'b0;
                        state_reg <= ST_EXEC;
                    end
                end
                ST_EXEC: begin
                    state_reg <= ST_OUT;
                    if (is_cmd) begin
                        if (busy) begin
                            rej_reg <= 1'b1;
                        end else if (func_reg == FUNC_DEFAULT ||
                                     func_reg == FUNC_COUNTED) begin
                            accum_reg <= {pd_reg, 8'h00};
                            if (func_reg == FUNC_DEFAULT ? (dflt_cnt_reg != 16'd0)
                                                         : (cnt_reg != 16'd0)) begin
                                mode_reg  <= MODE_CONST;
                                steps_reg <= (func_reg == FUNC_DEFAULT) ? dflt_cnt_reg
                                                                        : cnt_reg;
                                pulse_reg <= 1'b1;
                                hc_reg    <= (pd_reg == 16'd0) ? 16'd1 : pd_reg;
                            end
                        end else if (func_reg == FUNC_RAMP_UP) begin
                            idx_reg   <= '0;
                            len_reg   <= '0;
                            accum_reg <= {start_dly_reg, 8'h00};
                            if (cnt_reg != 16'd0) begin
                                len_reg   <= LW'(1);
                                mode_reg  <= MODE_UP;
                                steps_reg <= cnt_reg;
                                pulse_reg <= 1'b1;
                                hc_reg    <= (start_dly_reg == 16'd0) ? 16'd1
                                                                      : start_dly_reg;
                            end
                        end else if (n_down != 17'd0) begin
                            // ramp down: fetch the last entry to replay
                            idx_reg   <= n_m1[15:0];
                            mode_reg  <= MODE_DOWN;
                            steps_reg <= n_down[15:0];
                            state_reg <= ST_RD;
                        end
                    end else if (busy) begin
                        hc_reg <= hc_dec;
                        if (hc_dec == 16'd0) begin
                            if (pulse_reg) begin
                                pulse_reg <= 1'b0;
                                hc_reg    <= eff_delay(accum_reg);
                            end else begin
                                done_reg  <= 1'b1;
                                steps_reg <= sl_dec;
                                if (sl_dec == 16'd0) begin
                                    mode_reg <= MODE_IDLE;
                                end else if (mode_reg == MODE_UP) begin
                                    idx_reg   <= idx_inc;
                                    state_reg <= ST_DIV;
                                end else if (mode_reg == MODE_DOWN) begin
                                    idx_reg   <= idx_dec;
                                    state_reg <= ST_RD;
                                end else begin
                                    pulse_reg <= 1'b1;
                                    hc_reg    <= eff_delay(accum_reg);
                                end
                            end
                        end
                    end
                end
                ST_RD: begin
                    accum_reg <= {ram_rdata, 8'h00};
                    pulse_reg <= 1'b1;
                    hc_reg    <= rd_dly;
                    state_reg <= ST_OUT;
                end
                ST_DIV: begin
                    if (div_done) begin
                        accum_reg <= accum_new;
                        if (idx_in_range) begin
                            len_reg <= LW'({1'b0, idx_reg} + 17'd1);
                        end
                        pulse_reg <= 1'b1;
                        hc_reg    <= eff_delay(accum_new);
                        state_reg <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg <= 1'b1;
                        m_pulse_reg <= pulse_reg;
                        m_busy_reg  <= busy;
                        m_rej_reg   <= rej_reg;
                        m_done_reg  <= done_reg;
                        m_delay_reg <= busy ? eff_delay(accum_reg) : 16'd0;
                        state_reg   <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign s_ready         = state_reg == ST_IDLE;
    assign m_valid         = m_valid_reg;
    assign m_step_pulse    = m_pulse_reg;
    assign m_busy_res      = m_busy_reg;
    assign m_rejected      = m_rej_reg;
    assign m_step_done     = m_done_reg;
    assign m_current_delay = m_delay_reg;

endmodule

`default_nettype wire

[hw/rtl/srpg_ram.sv]
// Generic single-port synchronous RAM with registered read data.
// No dependencies.
`default_nettype none

module srpg_ram #(
    parameter int unsigned WIDTH = 16,
    parameter int unsigned DEPTH = 1024
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One access per cycle, read data in the cycle after the address
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

`default_nettype wire

[hw/rtl/srpg_div.sv]
// Restoring radix-2 divider for the ramp step, one quotient bit per cycle.
// Depends on srpg_pkg for the operand widths.
`default_nettype none

module srpg_div (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              start,
    input  wire logic [srpg_pkg::DIVIDEND_W-1:0]   dividend,
    input  wire logic [srpg_pkg::DIVISOR_W-1:0]    divisor,
    output logic                                   done,
    output logic      [srpg_pkg::DIVIDEND_W-1:0]   quotient
);
    import srpg_pkg::*;

    localparam int unsigned CNT_W = $clog2(DIVIDEND_W);

    logic                    busy_reg;
    logic [CNT_W-1:0]        cnt_reg;
    logic [DIVISOR_W:0]      rem_reg;
    logic [DIVIDEND_W-1:0]   quo_reg;
    logic [DIVISOR_W-1:0]    dvs_reg;
    logic                    done_reg;

    logic [DIVISOR_W:0]      trial;
    logic                    fits;

    // Shift in the next dividend bit and try the subtract
    always_comb begin
        trial = {rem_reg[DIVISOR_W-1:0], quo_reg[DIVIDEND_W-1]};
        fits  = trial >= {1'b0, dvs_reg};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(DIVIDEND_W - 1);
                rem_reg  <= '0;
                quo_reg  <= dividend;
                dvs_reg  <= divisor;
            end else if (busy_reg) begin
                rem_reg <= fits ? (trial - {1'b0, dvs_reg}) : trial;
                quo_reg <= {quo_reg[DIVIDEND_W-2:0], fits};
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire

[hw/rtl/srpg_checker.sv]
// Port-level checks for the stepper ramp pulse generator, bound to the core.
// Depends only on the core's ports.
`default_nettype none

module srpg_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        m_valid,
    input wire logic        m_ready,
    input wire logic        m_step_pulse,
    input wire logic        m_busy_res,
    input wire logic        m_rejected,
    input wire logic        m_step_done,
    input wire logic [15:0] m_current_delay
);

    // A rejected command only happens while a move runs
    a_rej_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_rejected |-> m_busy_res)
        else $error("rejected without busy");

    // Delay is nonzero exactly while busy
    a_delay_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_busy_res == (m_current_delay != 16'd0)))
        else $error("current_delay disagrees with busy");

    // Idle means the step output is low
    a_idle_low: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_busy_res |-> !m_step_pulse)
        else $error("step pulse high while idle");

    // A finished step starts the next high half, or ends the move low
    a_done_level: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_step_done |-> (m_step_pulse == m_busy_res))
        else $error("step_done with wrong pulse level");

    // A stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_current_delay))
        else $error("result changed while stalled");

endmodule

bind stepper_ramp_pulse_generator_core srpg_checker u_srpg_checker (.*);

`default_nettype wire

[dv/tb.sv]
// Self-checking testbench for stepper_ramp_pulse_generator_core.
// Drives ticks and move commands through valid/ready, predicts each result and checks it.
// Depends on srpg_pkg and the core RTL only.
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import srpg_pkg::*;

    localparam int unsigned TABLE_DEPTH = 1024;
    // func codes above ramp down behave as a tick
    localparam logic [2:0] FUNC_SPARE_LO = 3'd5;
    localparam logic [2:0] FUNC_SPARE_HI = 3'd7;
    // register index with no register behind it
    localparam logic [1:0] REG_UNUSED = 2'd3;
    localparam longint unsigned TICK_BUDGET = 600;
    localparam int SETTLE_CYCLES = 40;
    localparam int LONG_HOLD = 400;
    localparam int PHASE_ITEMS = 110;
    localparam int MAX_REPORTS = 100;

    typedef struct packed {
        logic [2:0]  func;
        logic [15:0] pd;
        logic [15:0] cnt;
    } cmd_t;

    typedef struct packed {
        logic        level;
        logic        busy;
        logic        rejected;
        logic        done;
        logic [15:0] delay;
    } pulse_out_t;

    typedef struct packed {
        cmd_t       c;
        logic       typed;
        pulse_out_t want;
    } step_row_t;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [2:0]  s_func;
    logic [15:0] s_pulse_delay;
    logic [15:0] s_step_count;
    logic        m_valid;
    logic        m_ready;
    logic        m_step_pulse;
    logic        m_busy_res;
    logic        m_rejected;
    logic        m_step_done;
    logic [15:0] m_current_delay;
    logic        cfg_wr_en;
    logic [1:0]  cfg_addr;
    logic [15:0] cfg_wr_data;

    stepper_ramp_pulse_generator_core #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) uut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_func(s_func),
        .s_pulse_delay(s_pulse_delay),
        .s_step_count(s_step_count),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_step_pulse(m_step_pulse),
        .m_busy_res(m_busy_res),
        .m_rejected(m_rejected),
        .m_step_done(m_step_done),
        .m_current_delay(m_current_delay),
        .cfg_wr_en(cfg_wr_en),
        .cfg_addr(cfg_addr),
        .cfg_wr_data(cfg_wr_data)
    );

    // Shadow copy of the generator state and its registers
    logic [15:0] cfg_default_count;
    logic [15:0] cfg_start_delay;
    logic [15:0] cfg_min_delay;
    mode_t       sh_mode;
    logic [15:0] sh_half;
    logic        sh_level;
    logic [15:0] sh_steps;
    logic [15:0] sh_idx;
    logic [23:0] sh_accum;
    int unsigned sh_len;
    logic [15:0] sh_table [TABLE_DEPTH];

    pulse_out_t pending_pulse_q [$];
    int         mismatches;
    bit         steady;
    bit         hold_req;

    // Directed bring-up rows; reset config (default count 200)
    step_row_t bringup [0:23] = '{
        '{'{FUNC_TICK,      16'h0000, 16'h0000}, 1'b1, '{1'b0, 1'b0, 1'b0, 1'b0, 16'd0}},
        '{'{FUNC_RAMP_DOWN, 16'h0000, 16'h0005}, 1'b1, '{1'b0, 1'b0, 1'b0, 1'b0, 16'd0}},
        '{'{FUNC_COUNTED,   16'h0007, 16'h0000}, 1'b1, '{1'b0, 1'b0, 1'b0, 1'b0, 16'd0}},
        '{'{FUNC_RAMP_UP,   16'h0000, 16'h0000}, 1'b1, '{1'b0, 1'b0, 1'b0, 1'b0, 16'd0}},
        '{'{FUNC_SPARE_LO,  16'hFFFF, 16'hFFFF}, 1'b1, '{1'b0, 1'b0, 1'b0, 1'b0, 16'd0}},
        '{'{FUNC_SPARE_HI,  16'hAAAA, 16'h5555}, 1'b1, '{1'b0, 1'b0, 1'b0, 1'b0, 16'd0}},
        // zero half period runs as one tick
        '{'{FUNC_COUNTED,   16'h0000, 16'h0002}, 1'b1, '{1'b1, 1'b1, 1'b0, 1'b0, 16'd1}},
        '{'{FUNC_DEFAULT,   16'hFFFF, 16'hFFFF}, 1'b1, '{1'b1, 1'b1, 1'b1, 1'b0, 16'd1}},
        '{'{FUNC_RAMP_UP,   16'h0000, 16'h0000}, 1'b1, '{1'b1, 1'b1, 1'b1, 1'b0, 16'd1}},
        '{'{FUNC_RAMP_DOWN, 16'h5555, 16'hAAAA}, 1'b1, '{1'b1, 1'b1, 1'b1, 1'b0, 16'd1}},
        '{'{FUNC_TICK,      16'h0000, 16'h0000}, 1'b1, '{1'b0, 1'b1, 1'b0, 1'b0, 16'd1}},
        '{'{FUNC_TICK,      16'h0000, 16'h0000}, 1'b1, '{1'b1, 1'b1, 1'b0, 1'b1, 16'd1}},
        '{'{FUNC_TICK,      16'hFFFF, 16'hFFFF}, 1'b1, '{1'b0, 1'b1, 1'b0, 1'b0, 16'd1}},
        '{'{FUNC_TICK,      16'h0000, 16'h0000}, 1'b1, '{1'b0, 1'b0, 1'b0, 1'b1, 16'd0}},
        '{'{FUNC_COUNTED,   16'h0003, 16'h0001}, 1'b1, '{1'b1, 1'b1, 1'b0, 1'b0, 16'd3}},
        '{'{FUNC_COUNTED,   16'h0009, 16'h0009}, 1'b1, '{1'b1, 1'b1, 1'b1, 1'b0, 16'd3}},
        '{'{FUNC_TICK,      16'h1234, 16'h0000}, 1'b0, '0},
        '{'{FUNC_TICK,      16'h0000, 16'h4321}, 1'b0, '0},
        '{'{FUNC_TICK,      16'h0000, 16'h0000}, 1'b0, '0},
        '{'{FUNC_TICK,      16'h0000, 16'h0000}, 1'b0, '0},
        '{'{FUNC_TICK,      16'h0000, 16'h0000}, 1'b0, '0},
        '{'{FUNC_TICK,      16'h0000, 16'h0000}, 1'b0, '0},
        '{'{FUNC_DEFAULT,   16'h0001, 16'h0000}, 1'b1, '{1'b1, 1'b1, 1'b0, 1'b0, 16'd1}},
        '{'{FUNC_TICK,      16'h0000, 16'h0000}, 1'b0, '0}
    };

    // Integer half period of the shadow accumulator, zero runs as one
    function automatic logic [15:0] half_period();
        logic [15:0] d;
        d = sh_accum[23:8];
        return (d == 16'd0) ? 16'd1 : d;
    endfunction

    // Store the current half period unless the table is full
    function automatic void log_half_period();
        if (sh_idx < TABLE_DEPTH) begin
            sh_table[sh_idx] = sh_accum[23:8];
            sh_len = 32'(sh_idx) + 1;
        end
    endfunction

    function automatic void launch_step();
        sh_level = 1'b1;
        sh_half  = half_period();
    endfunction

    function automatic void launch_move(input mode_t m, input logic [15:0] n);
        if (n == 16'd0)
            return;
        sh_mode  = m;
        sh_steps = n;
        launch_step();
    endfunction

    // Advance the shadow by one accepted item and return its result
    function automatic pulse_out_t predict_pulse(input cmd_t c);
        pulse_out_t  r;
        logic [31:0] a;
        logic [31:0] divisor;
        logic [31:0] lim;
        logic [15:0] n;
        r = '0;
        if (c.func >= FUNC_DEFAULT && c.func <= FUNC_RAMP_DOWN) begin
            if (sh_mode != MODE_IDLE) begin
                r.rejected = 1'b1;
            end else begin
                case (c.func)
                    FUNC_DEFAULT, FUNC_COUNTED: begin
                        sh_accum = {c.pd, 8'h00};
                        launch_move(MODE_CONST,
                                    (c.func == FUNC_DEFAULT) ? cfg_default_count : c.cnt);
                    end
                    FUNC_RAMP_UP: begin
                        sh_idx   = 16'd0;
                        sh_len   = 0;
                        sh_accum = {cfg_start_delay, 8'h00};
                        if (c.cnt != 16'd0) begin
                            log_half_period();
                            launch_move(MODE_UP, c.cnt);
                        end
                    end
                    default: begin
                        // replay only what was recorded
                        n = (c.cnt < sh_len) ? c.cnt : 16'(sh_len);
                        if (n != 16'd0) begin
                            sh_idx   = n - 16'd1;
                            sh_accum = {sh_table[sh_idx], 8'h00};
                            launch_move(MODE_DOWN, n);
                        end
                    end
                endcase
            end
        end else if (sh_mode != MODE_IDLE) begin
            sh_half = sh_half - 16'd1;
            if (sh_half == 16'd0) begin
                if (sh_level) begin
                    sh_level = 1'b0;
                    sh_half  = half_period();
                end else begin
                    r.done   = 1'b1;
                    sh_steps = sh_steps - 16'd1;
                    if (sh_steps == 16'd0) begin
                        sh_mode = MODE_IDLE;
                    end else begin
                        if (sh_mode == MODE_UP) begin
                            // a - 2a/(4i+1), floored at the minimum delay
                            sh_idx  = sh_idx + 16'd1;
                            divisor = (32'(sh_idx) << 2) + 32'd1;
                            a       = {8'h00, sh_accum};
                            a       = a - (2 * a) / divisor;
                            lim     = {8'h00, cfg_min_delay, 8'h00};
                            if (a < lim)
                                a = lim;
                            sh_accum = a[23:0];
                            log_half_period();
                        end else if (sh_mode == MODE_DOWN) begin
                            sh_idx = sh_idx - 16'd1;
                            if (sh_idx < TABLE_DEPTH)
                                sh_accum = {sh_table[sh_idx], 8'h00};
                        end
                        launch_step();
                    end
                end
            end
        end
        r.level = sh_level;
        r.busy  = (sh_mode != MODE_IDLE);
        r.delay = r.busy ? half_period() : 16'd0;
        return r;
    endfunction

    // Ticks taken by a full period at half period d
    function automatic longint unsigned ticks_of(input logic [15:0] d);
        return (d == 16'd0) ? 64'd2 : 64'd2 * 64'(d);
    endfunction

    // Upper bound on the ticks a command started from idle would run
    function automatic longint unsigned move_ticks(input cmd_t c);
        longint unsigned total;
        logic [15:0]     n;
        total = 0;
        case (c.func)
            FUNC_DEFAULT: total = 64'(cfg_default_count) * ticks_of(c.pd);
            FUNC_COUNTED: total = 64'(c.cnt) * ticks_of(c.pd);
            FUNC_RAMP_UP: total = 64'(c.cnt) * ticks_of((cfg_start_delay > cfg_min_delay) ?
                                                         cfg_start_delay : cfg_min_delay);
            FUNC_RAMP_DOWN: begin
                n = (c.cnt < sh_len) ? c.cnt : 16'(sh_len);
                for (int k = 0; k < int'(n); k++)
                    total += ticks_of(sh_table[k]);
            end
            default: total = 0;
        endcase
        return total;
    endfunction

    // Mostly ticks; commands issued from idle stay short
    function automatic cmd_t gen_item();
        cmd_t c;
        int   r;
        r     = $urandom_range(0, 99);
        c.pd  = 16'($urandom);
        c.cnt = 16'($urandom);
        if (r < 72)
            c.func = FUNC_TICK;
        else if (r < 76)
            c.func = 3'($urandom_range(FUNC_SPARE_LO, FUNC_SPARE_HI));
        else
            c.func = 3'($urandom_range(FUNC_DEFAULT, FUNC_RAMP_DOWN));
        if (sh_mode == MODE_IDLE && c.func >= FUNC_DEFAULT && c.func <= FUNC_RAMP_DOWN) begin
            r    = $urandom_range(0, 99);
            c.pd = (r < 85) ? 16'($urandom_range(0, 6)) : 16'($urandom_range(7, 40));
            r    = $urandom_range(0, 99);
            if (r < 10)
                c.cnt = 16'd0;
            else if (r < 85)
                c.cnt = 16'($urandom_range(1, 6));
            else if (r < 95)
                c.cnt = 16'($urandom_range(7, 24));
            else
                c.cnt = 16'hFFFF;
            if (move_ticks(c) > TICK_BUDGET)
                c.func = FUNC_TICK;
        end
        return c;
    endfunction

    // Idle cycles: mostly none, some short, a few long
    function automatic int pick_gap();
        int r;
        if (steady)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // Offer one item, wait for the transfer, then log its expected result
    task automatic send_item(input cmd_t c, input logic typed, input pulse_out_t want);
        int         gap;
        pulse_out_t predicted;
        gap = pick_gap();
        @(negedge aclk);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid       <= 1'b1;
        s_func        <= c.func;
        s_pulse_delay <= c.pd;
        s_step_count  <= c.cnt;
        do
            @(posedge aclk);
        while (!s_ready);
        predicted = predict_pulse(c);
        pending_pulse_q.push_back(typed ? want : predicted);
    endtask

    // Tick until the move in progress ends, then let every result drain
    task automatic finish_moves();
        cmd_t c;
        while (sh_mode != MODE_IDLE) begin
            c.func = FUNC_TICK;
            c.pd   = 16'($urandom);
            c.cnt  = 16'($urandom);
            send_item(c, 1'b0, '0);
        end
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_pulse_q.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
        @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_addr    <= idx;
        cfg_wr_data <= val;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            REG_DEFAULT_COUNT: cfg_default_count = val;
            REG_START_DELAY:   cfg_start_delay = val;
            REG_MIN_DELAY:     cfg_min_delay = val;
            default: ;
        endcase
    endtask

    task automatic set_config(input logic [15:0] def_cnt, input logic [15:0] start_d,
                              input logic [15:0] min_d);
        write_reg(REG_DEFAULT_COUNT, def_cnt);
        write_reg(REG_START_DELAY, start_d);
        write_reg(REG_MIN_DELAY, min_d);
        write_reg(REG_UNUSED, 16'($urandom));
    endtask

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
        end
    endtask

    // Clock
    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // Result side: random stalls, one long hold-off on request
    initial begin : result_sink
        int gap;
        m_ready = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                m_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
                hold_req = 1'b0;
            end else begin
                gap = pick_gap();
                m_ready <= (gap == 0);
                if (gap > 1)
                    repeat (gap - 1) @(negedge aclk);
            end
        end
    end

    // Compare each result transfer with the oldest expectation
    always @(posedge aclk) begin : check_results
        pulse_out_t oldest;
        if (aresetn && m_valid && m_ready) begin
            if (pending_pulse_q.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("%0t: result transfer with nothing expected", $time);
            end else begin
                oldest = pending_pulse_q.pop_front();
                check_field("step_pulse", oldest.level, m_step_pulse);
                check_field("busy_res", oldest.busy, m_busy_res);
                check_field("rejected", oldest.rejected, m_rejected);
                check_field("step_done", oldest.done, m_step_done);
                check_field("current_delay", oldest.delay, m_current_delay);
            end
        end
    end

    // Stimulus
    initial begin : stimulus
        cmd_t c;
        aresetn       = 1'b0;
        s_valid       = 1'b0;
        s_func        = FUNC_TICK;
        s_pulse_delay = 16'd0;
        s_step_count  = 16'd0;
        cfg_wr_en     = 1'b0;
        cfg_addr      = REG_DEFAULT_COUNT;
        cfg_wr_data   = 16'd0;
        mismatches    = 0;
        steady        = 1'b0;
        hold_req      = 1'b0;
        cfg_default_count = RST_DEFAULT_COUNT;
        cfg_start_delay   = RST_START_DELAY;
        cfg_min_delay     = RST_MIN_DELAY;
        sh_mode  = MODE_IDLE;
        sh_half  = 16'd0;
        sh_level = 1'b0;
        sh_steps = 16'd0;
        sh_idx   = 16'd0;
        sh_accum = 24'd0;
        sh_len   = 0;
        foreach (sh_table[k])
            sh_table[k] = 16'd0;

        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed bring-up with reset register values
        foreach (bringup[k])
            send_item(bringup[k].c, bringup[k].typed, bringup[k].want);
        finish_moves();

        // Short ramp, then replay with a count beyond what was recorded
        set_config(16'd0, 16'd2, 16'd1);
        c = '{FUNC_RAMP_UP, 16'($urandom), 16'd20};
        send_item(c, 1'b0, '0);
        finish_moves();
        c = '{FUNC_RAMP_DOWN, 16'($urandom), 16'hFFFF};
        send_item(c, 1'b0, '0);
        finish_moves();
        // default count of zero leaves the block idle
        c = '{FUNC_DEFAULT, 16'd5, 16'($urandom)};
        send_item(c, 1'b1, '0);
        c = '{FUNC_RAMP_DOWN, 16'd0, 16'd3};
        send_item(c, 1'b0, '0);
        finish_moves();

        // Random phases over several register settings
        for (int ph = 0; ph < 8; ph++) begin
            case (ph)
                0: set_config(16'd3, 16'd1, 16'd1);
                1: set_config(16'hFFFF, 16'hFFFF, 16'hFFFF);
                2: set_config(16'd4, 16'd40, 16'd0);
                3: set_config(16'd2, 16'd0, 16'd3);
                default: set_config(16'($urandom_range(0, 8)), 16'($urandom_range(0, 60)),
                                    16'($urandom_range(0, 25)));
            endcase
            steady   = (ph == 3);
            hold_req = (ph == 1);
            for (int n = 0; n < PHASE_ITEMS; n++)
                send_item(gen_item(), 1'b0, '0);
            finish_moves();
            steady = 1'b0;
        end

        if (mismatches == 0 && pending_pulse_q.size() == 0)
            $display("PASS stepper_ramp_pulse_generator_core");
        else
            $display("FAIL stepper_ramp_pulse_generator_core");
        $finish;
    end

    // Watchdog
    initial begin
        #20_000_000;
        $display("FAIL stepper_ramp_pulse_generator_core");
        $finish;
    end

endmodule

`default_nettype wire

[files.f]
hw/rtl/srpg_pkg.sv
hw/rtl/srpg_ram.sv
hw/rtl/srpg_div.sv
hw/rtl/stepper_ramp_pulse_generator_core.sv
hw/rtl/srpg_checker.sv
dv/tb.sv
